FILE: src/i2t_pkg.sv
// shared types and constants of the i2t overcurrent watchdog
package i2t_pkg;

    localparam int REG_SETS      = 4;
    localparam int MOTOR_W       = 2;
    localparam int CUR_W         = 16;
    localparam int CFG_W         = 15;
    localparam int CFG_IDX_W     = 3;
    localparam int SQ_W          = 31;
    localparam int DELTA_W       = 33;
    localparam int THR_W         = 44;
    localparam int ACC_W         = 48;
    localparam int SUM_W         = 50;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QCNT_W        = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_BASE    = 3'd4;

    localparam logic [THR_W-1:0] THR_SCALE = 44'd3000;
    localparam logic [ACC_W-1:0] ACC_MAX   = {ACC_W{1'b1}};

    typedef struct packed {
        logic [MOTOR_W-1:0]        motor;
        logic signed [CUR_W-1:0]   cur;
        logic                      served;
        logic signed [DELTA_W-1:0] delta;
        logic signed [THR_W-1:0]   thr;
        logic                      vvalid;
        logic signed [CUR_W-1:0]   voltage;
    } t_item;

endpackage

FILE: src/i2t_queue.sv
// short item queue between the classifying front and the accumulator back
module i2t_queue #(
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  i2t_pkg::t_item               i_item,
    input  logic                         i_pop,
    output i2t_pkg::t_item               o_head,
    output logic                         o_empty,
    output logic [i2t_pkg::QCNT_W-1:0]   o_count
);
    import i2t_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    t_item             r_mem [DEPTH];
    logic [AW-1:0]     r_wr, n_wr;
    logic [AW-1:0]     r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;

endmodule

FILE: src/i2t_front.sv
// intake: configuration, tick decimator, squares and thresholds
module i2t_front #(
    parameter int SERVED         = 4,
    parameter int VOLTAGE_PERIOD = 500
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [i2t_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [i2t_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [i2t_pkg::MOTOR_W-1:0]         i_motor_index,
    input  logic signed [i2t_pkg::CUR_W-1:0]    i_current_sample,
    input  logic signed [i2t_pkg::CUR_W-1:0]    i_supply_voltage,
    input  logic                                i_tick_end,
    input  logic [i2t_pkg::QCNT_W-1:0]          i_queue_count,
    output logic                                o_push,
    output i2t_pkg::t_item                      o_item
);
    import i2t_pkg::*;

    localparam int TW = $clog2(VOLTAGE_PERIOD + 1);

    logic [CFG_W-1:0]        r_nom  [REG_SETS];
    logic [CFG_W-1:0]        r_peak [REG_SETS];
    logic [TW-1:0]           r_tick, n_tick;
    logic signed [CUR_W-1:0] r_volt, n_volt;
    logic                    n_vvalid;

    logic                    r_s1_valid;
    logic [MOTOR_W-1:0]      r_s1_motor;
    logic signed [CUR_W-1:0] r_s1_cur;
    logic                    r_s1_served;
    logic [SQ_W-1:0]         r_s1_cur2;
    logic [SQ_W-1:0]         r_s1_nom2;
    logic [SQ_W-1:0]         r_s1_pk2;
    logic                    r_s1_vvalid;
    logic signed [CUR_W-1:0] r_s1_volt;

    logic                    r_s2_valid;
    t_item                   r_s2_item;

    logic                    accept;
    logic [QCNT_W:0]         inflight;
    logic [TW-1:0]           tick_inc;
    logic signed [2*CUR_W-1:0] cur_sq;
    logic [2*CFG_W-1:0]      nom_sq;
    logic [2*CFG_W-1:0]      pk_sq;
    logic signed [THR_W-1:0] diff;
    t_item                   s2_item;

    assign inflight   = (QCNT_W+1)'(i_queue_count) + (QCNT_W+1)'(r_s1_valid)
                      + (QCNT_W+1)'(r_s2_valid);
    assign o_in_stall = (inflight >= (QCNT_W+1)'(QUEUE_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < REG_SETS; k++) begin
                r_nom[k]  <= '0;
                r_peak[k] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index < CFG_PEAK_BASE) begin
                r_nom[i_cfg_index[1:0]] <= i_cfg_data;
            end else begin
                r_peak[i_cfg_index[1:0]] <= i_cfg_data;
            end
        end
    end

    // tick decimator
    always_comb begin
        tick_inc = r_tick + 1'b1;
        n_tick   = r_tick;
        n_volt   = r_volt;
        n_vvalid = 1'b0;
        if (i_tick_end) begin
            n_tick = tick_inc;
            if (tick_inc >= TW'(VOLTAGE_PERIOD)) begin
                n_tick   = '0;
                n_volt   = i_supply_voltage;
                n_vvalid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            r_volt <= '0;
        end else if (accept) begin
            r_tick <= n_tick;
            r_volt <= n_volt;
        end
    end

    // stage one: squares
    assign cur_sq = i_current_sample * i_current_sample;
    assign nom_sq = r_nom[i_motor_index] * r_nom[i_motor_index];
    assign pk_sq  = r_peak[i_motor_index] * r_peak[i_motor_index];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_motor  <= i_motor_index;
            r_s1_cur    <= i_current_sample;
            r_s1_served <= ({1'b0, i_motor_index} < (MOTOR_W+1)'(SERVED));
            r_s1_cur2   <= cur_sq[SQ_W-1:0];
            r_s1_nom2   <= SQ_W'(nom_sq);
            r_s1_pk2    <= SQ_W'(pk_sq);
            r_s1_vvalid <= n_vvalid;
            r_s1_volt   <= n_volt;
        end
    end

    // stage two: energy step and threshold
    always_comb begin
        diff            = $signed(THR_W'(r_s1_pk2)) - $signed(THR_W'(r_s1_nom2));
        s2_item.motor   = r_s1_motor;
        s2_item.cur     = r_s1_cur;
        s2_item.served  = r_s1_served;
        s2_item.delta   = $signed(DELTA_W'(r_s1_cur2)) - $signed(DELTA_W'(r_s1_nom2));
        s2_item.thr     = diff * $signed(THR_SCALE);
        s2_item.vvalid  = r_s1_vvalid;
        s2_item.voltage = r_s1_volt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_s2_item <= s2_item;
        end
    end

    assign o_push = r_s2_valid;
    assign o_item = r_s2_item;

endmodule

FILE: src/i2t_back.sv
// accumulator update, fault hysteresis and result register
module i2t_back #(
    parameter int SERVED = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_empty,
    input  i2t_pkg::t_item                      i_head,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [i2t_pkg::MOTOR_W-1:0]         o_motor_echo,
    output logic signed [i2t_pkg::CUR_W-1:0]    o_current_feedback,
    output logic                                o_fault_raise,
    output logic                                o_fault_cleared,
    output logic                                o_voltage_valid,
    output logic signed [i2t_pkg::CUR_W-1:0]    o_published_voltage
);
    import i2t_pkg::*;

    localparam int IW = (SERVED > 1) ? $clog2(SERVED) : 1;

    logic [ACC_W-1:0]        r_acc   [SERVED];
    logic                    r_latch [SERVED];

    logic                    r_out_valid;
    logic [MOTOR_W-1:0]      r_motor;
    logic signed [CUR_W-1:0] r_cur;
    logic                    r_raise, n_raise;
    logic                    r_cleared, n_cleared;
    logic                    r_vvalid;
    logic signed [CUR_W-1:0] r_volt;

    logic [IW-1:0]           idx;
    logic signed [SUM_W-1:0] sum;
    logic [ACC_W-1:0]        n_acc;
    logic                    n_latch;
    logic signed [ACC_W:0]   acc_s;
    logic signed [ACC_W:0]   thr_s;
    logic signed [ACC_W:0]   half_s;

    assign o_pop = !i_empty && (!r_out_valid || !i_out_stall);
    assign idx   = i_head.motor[IW-1:0];

    always_comb begin
        sum       = $signed({2'b00, r_acc[idx]}) + SUM_W'(i_head.delta);
        if (sum < 0) begin
            n_acc = '0;
        end else if (sum > $signed({2'b00, ACC_MAX})) begin
            n_acc = ACC_MAX;
        end else begin
            n_acc = sum[ACC_W-1:0];
        end
        acc_s     = $signed({1'b0, n_acc});
        thr_s     = (ACC_W+1)'(i_head.thr);
        half_s    = (ACC_W+1)'(i_head.thr >>> 1);
        n_latch   = r_latch[idx];
        n_raise   = 1'b0;
        n_cleared = 1'b0;
        if (acc_s > thr_s) begin
            n_latch = 1'b1;
            n_raise = 1'b1;
        end else if (r_latch[idx]) begin
            if (acc_s > half_s) begin
                n_raise = 1'b1;
            end else begin
                n_latch   = 1'b0;
                n_cleared = 1'b1;
            end
        end
        if (!i_head.served) begin
            n_raise   = 1'b0;
            n_cleared = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SERVED; k++) begin
                r_acc[k]   <= '0;
                r_latch[k] <= 1'b0;
            end
        end else if (o_pop && i_head.served) begin
            r_acc[idx]   <= n_acc;
            r_latch[idx] <= n_latch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_motor   <= i_head.motor;
            r_cur     <= i_head.cur;
            r_raise   <= n_raise;
            r_cleared <= n_cleared;
            r_vvalid  <= i_head.vvalid;
            r_volt    <= i_head.voltage;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_motor_echo        = r_motor;
    assign o_current_feedback  = r_cur;
    assign o_fault_raise       = r_raise;
    assign o_fault_cleared     = r_cleared;
    assign o_voltage_valid     = r_vvalid;
    assign o_published_voltage = r_volt;

endmodule

FILE: src/i2t_motor_overcurrent_watchdog.sv
// top level of the i2t motor overcurrent watchdog
// Takes one current sample item per clock while o_in_stall is low and returns one
// result item per sample, in order. An item spends two front stages (squares, then
// energy step and threshold), passes a four-entry queue and reaches the output
// register through one accumulator update. The queue depth counted against the front
// stages sets how many items are taken while the output is stalled; with the output
// free the sustained rate is one item per cycle, and the accumulator read-modify-write
// per motor does not hold it back.
module i2t_motor_overcurrent_watchdog #(
    parameter int MOTOR_COUNT    = 4,
    parameter int VOLTAGE_PERIOD = 500
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [i2t_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [i2t_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [i2t_pkg::MOTOR_W-1:0]         i_motor_index,
    input  logic signed [i2t_pkg::CUR_W-1:0]    i_current_sample,
    input  logic signed [i2t_pkg::CUR_W-1:0]    i_supply_voltage,
    input  logic                                i_tick_end,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [i2t_pkg::MOTOR_W-1:0]         o_motor_echo,
    output logic signed [i2t_pkg::CUR_W-1:0]    o_current_feedback,
    output logic                                o_fault_raise,
    output logic                                o_fault_cleared,
    output logic                                o_voltage_valid,
    output logic signed [i2t_pkg::CUR_W-1:0]    o_published_voltage
);
    import i2t_pkg::*;

    localparam int SERVED = (MOTOR_COUNT < REG_SETS) ? MOTOR_COUNT : REG_SETS;

    logic              push;
    t_item             push_item;
    logic              pop;
    t_item             head;
    logic              empty;
    logic [QCNT_W-1:0] qcount;

    i2t_front #(
        .SERVED         (SERVED),
        .VOLTAGE_PERIOD (VOLTAGE_PERIOD)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_motor_index    (i_motor_index),
        .i_current_sample (i_current_sample),
        .i_supply_voltage (i_supply_voltage),
        .i_tick_end       (i_tick_end),
        .i_queue_count    (qcount),
        .o_push           (push),
        .o_item           (push_item)
    );

    i2t_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_count (qcount)
    );

    i2t_back #(
        .SERVED (SERVED)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_empty             (empty),
        .i_head              (head),
        .o_pop               (pop),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_motor_echo        (o_motor_echo),
        .o_current_feedback  (o_current_feedback),
        .o_fault_raise       (o_fault_raise),
        .o_fault_cleared     (o_fault_cleared),
        .o_voltage_valid     (o_voltage_valid),
        .o_published_voltage (o_published_voltage)
    );

endmodule

FILE: tb/tb_i2t_motor_overcurrent_watchdog.sv
// self-checking testbench of the i2t overcurrent watchdog with its own prediction
`timescale 1ns / 100ps

module tb_i2t_motor_overcurrent_watchdog;

    localparam int MOTORS       = 4;
    localparam int VOLT_PERIOD  = 500;
    localparam int IDLE_PCT     = 31;
    localparam int RANDOM_SETS  = 4;
    localparam int SET_SAMPLES  = 180;
    localparam int SURGE_SAMPLES = 100;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int PRINT_LIMIT  = 40;
    localparam longint ENERGY_CEIL = (longint'(1) << i2t_pkg::ACC_W) - 1;

    typedef struct packed {
        logic [i2t_pkg::MOTOR_W-1:0]      motor;
        logic signed [i2t_pkg::CUR_W-1:0] cur;
        logic signed [i2t_pkg::CUR_W-1:0] volt;
        logic                             tick;
    } t_sample;

    typedef struct packed {
        logic [i2t_pkg::MOTOR_W-1:0]      motor;
        logic signed [i2t_pkg::CUR_W-1:0] feedback;
        logic                             raise;
        logic                             cleared;
        logic                             vvalid;
        logic signed [i2t_pkg::CUR_W-1:0] volt;
    } t_verdict;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [i2t_pkg::CFG_IDX_W-1:0]       i_cfg_index;
    logic [i2t_pkg::CFG_W-1:0]           i_cfg_data;
    logic                                i_in_valid;
    logic                                o_in_stall;
    logic [i2t_pkg::MOTOR_W-1:0]         i_motor_index;
    logic signed [i2t_pkg::CUR_W-1:0]    i_current_sample;
    logic signed [i2t_pkg::CUR_W-1:0]    i_supply_voltage;
    logic                                i_tick_end;
    logic                                o_out_valid;
    logic                                i_out_stall;
    logic [i2t_pkg::MOTOR_W-1:0]         o_motor_echo;
    logic signed [i2t_pkg::CUR_W-1:0]    o_current_feedback;
    logic                                o_fault_raise;
    logic                                o_fault_cleared;
    logic                                o_voltage_valid;
    logic signed [i2t_pkg::CUR_W-1:0]    o_published_voltage;

    i2t_motor_overcurrent_watchdog #(
        .MOTOR_COUNT    (MOTORS),
        .VOLTAGE_PERIOD (VOLT_PERIOD)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_motor_index       (i_motor_index),
        .i_current_sample    (i_current_sample),
        .i_supply_voltage    (i_supply_voltage),
        .i_tick_end          (i_tick_end),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_motor_echo        (o_motor_echo),
        .o_current_feedback  (o_current_feedback),
        .o_fault_raise       (o_fault_raise),
        .o_fault_cleared     (o_fault_cleared),
        .o_voltage_valid     (o_voltage_valid),
        .o_published_voltage (o_published_voltage)
    );

    // predictor state and its copy of the ratings
    logic [i2t_pkg::CFG_W-1:0]        nominal [MOTORS];
    logic [i2t_pkg::CFG_W-1:0]        peak [MOTORS];
    longint                           energy [MOTORS];
    bit                               tripped [MOTORS];
    int                               tick_count = 0;
    logic signed [i2t_pkg::CUR_W-1:0] held_voltage = '0;

    logic [i2t_pkg::CFG_W-1:0] next_nominal [MOTORS];
    logic [i2t_pkg::CFG_W-1:0] next_peak [MOTORS];

    t_sample  queued_samples[$];
    t_verdict due_verdicts[$];
    bit       in_taken;
    bit       no_idle;
    int       errors;
    int       cycle_count;
    int       samples_sent;
    int       verdicts_checked;
    int       trips_seen;
    int       releases_seen;
    int       publishes_seen;
    int       rating_sets;

    function automatic t_verdict predict_overload(t_sample s);
        t_verdict v;
        longint   nom2;
        longint   diff;
        longint   acc;
        v.motor    = s.motor;
        v.feedback = s.cur;
        v.raise    = 1'b0;
        v.cleared  = 1'b0;
        v.vvalid   = 1'b0;
        nom2 = longint'(nominal[s.motor]) * longint'(nominal[s.motor]);
        diff = longint'(peak[s.motor]) * longint'(peak[s.motor]) - nom2;
        acc  = energy[s.motor] + longint'(s.cur) * longint'(s.cur) - nom2;
        if (acc < 0) acc = 0;
        if (acc > ENERGY_CEIL) acc = ENERGY_CEIL;
        energy[s.motor] = acc;
        if (acc > 3000 * diff) begin
            tripped[s.motor] = 1'b1;
            v.raise = 1'b1;
        end else if (tripped[s.motor]) begin
            if (acc > 1500 * diff) begin
                v.raise = 1'b1;
            end else begin
                tripped[s.motor] = 1'b0;
                v.cleared = 1'b1;
            end
        end
        if (s.tick) begin
            tick_count++;
            if (tick_count >= VOLT_PERIOD) begin
                tick_count   = 0;
                held_voltage = s.volt;
                v.vvalid     = 1'b1;
            end
        end
        v.volt = held_voltage;
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        if (errors < PRINT_LIMIT)
            $display("mismatch at result %0d: %s", verdicts_checked, what);
        errors++;
    endtask

    task automatic queue_sample(input int m, input int cur, input int volt, input bit tick);
        t_sample s;
        s.motor = (i2t_pkg::MOTOR_W)'(m);
        s.cur   = (i2t_pkg::CUR_W)'(cur);
        s.volt  = (i2t_pkg::CUR_W)'(volt);
        s.tick  = tick;
        queued_samples.push_back(s);
    endtask

    task automatic settle();
        while (queued_samples.size() != 0 || due_verdicts.size() != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic load_ratings();
        for (int m = 0; m < MOTORS; m++) begin
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= i2t_pkg::CFG_NOMINAL_BASE + (i2t_pkg::CFG_IDX_W)'(m);
            i_cfg_data  <= next_nominal[m];
            nominal[m]  = next_nominal[m];
        end
        for (int m = 0; m < MOTORS; m++) begin
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= i2t_pkg::CFG_PEAK_BASE + (i2t_pkg::CFG_IDX_W)'(m);
            i_cfg_data  <= next_peak[m];
            peak[m]     = next_peak[m];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        rating_sets++;
    endtask

    task automatic pick_ratings();
        int kind;
        for (int m = 0; m < MOTORS; m++) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                next_nominal[m] = (i2t_pkg::CFG_W)'($urandom_range(800, 4000));
                next_peak[m]    = next_nominal[m]
                                + (i2t_pkg::CFG_W)'($urandom_range(0, 3));
            end else if (kind < 9) begin
                next_nominal[m] = (i2t_pkg::CFG_W)'($urandom);
                next_peak[m]    = (i2t_pkg::CFG_W)'($urandom_range(0,
                                                    int'(next_nominal[m])));
            end else begin
                next_nominal[m] = (i2t_pkg::CFG_W)'($urandom);
                next_peak[m]    = (i2t_pkg::CFG_W)'($urandom);
            end
        end
    endtask

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin : timeout
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, due_verdicts.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // driver: new item after acceptance, random idling on both sides unless no_idle is set
    always @(negedge i_clk) begin : driver
        t_sample s;
        if (i_rst_n !== 1'b1) begin
            i_in_valid       <= 1'b0;
            i_out_stall      <= 1'b0;
            i_motor_index    <= '0;
            i_current_sample <= '0;
            i_supply_voltage <= '0;
            i_tick_end       <= 1'b0;
        end else begin
            if (!i_in_valid || in_taken) begin
                if (queued_samples.size() != 0 &&
                    (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    s = queued_samples.pop_front();
                    i_motor_index    <= s.motor;
                    i_current_sample <= s.cur;
                    i_supply_voltage <= s.volt;
                    i_tick_end       <= s.tick;
                    i_in_valid       <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // monitor: predict on acceptance, check each result against the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_sample  s;
        t_verdict want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                s.motor = i_motor_index;
                s.cur   = i_current_sample;
                s.volt  = i_supply_voltage;
                s.tick  = i_tick_end;
                due_verdicts.push_back(predict_overload(s));
                samples_sent++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (due_verdicts.size() == 0) begin
                    report_mismatch("result with no item pending");
                end else begin
                    want = due_verdicts.pop_front();
                    if (o_motor_echo !== want.motor)
                        report_mismatch($sformatf("motor_echo got %0d want %0d",
                                                  o_motor_echo, want.motor));
                    if (o_current_feedback !== want.feedback)
                        report_mismatch($sformatf("current_feedback got %0d want %0d",
                                                  o_current_feedback, want.feedback));
                    if (o_fault_raise !== want.raise)
                        report_mismatch($sformatf("fault_raise got %0b want %0b motor %0d",
                                                  o_fault_raise, want.raise, want.motor));
                    if (o_fault_cleared !== want.cleared)
                        report_mismatch($sformatf("fault_cleared got %0b want %0b motor %0d",
                                                  o_fault_cleared, want.cleared, want.motor));
                    if (o_voltage_valid !== want.vvalid)
                        report_mismatch($sformatf("voltage_valid got %0b want %0b",
                                                  o_voltage_valid, want.vvalid));
                    if (o_published_voltage !== want.volt)
                        report_mismatch($sformatf("published_voltage got %0d want %0d",
                                                  o_published_voltage, want.volt));
                    trips_seen     += int'(want.raise);
                    releases_seen  += int'(want.cleared);
                    publishes_seen += int'(want.vvalid);
                end
                verdicts_checked++;
            end
        end
    end

    initial begin : stimulus
        bit surging [MOTORS];
        int m;
        int roll;
        int base;
        int low;
        int top;
        int mag;
        int cur;
        for (int k = 0; k < MOTORS; k++) begin
            nominal[k] = '0;
            peak[k]    = '0;
            surging[k] = 1'b0;
        end
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        no_idle          = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero ratings, full ratings, peak below nominal, tight hysteresis
        next_nominal[0] = 0;     next_peak[0] = 0;
        next_nominal[1] = 32767; next_peak[1] = 32767;
        next_nominal[2] = 1000;  next_peak[2] = 10;
        next_nominal[3] = 1000;  next_peak[3] = 1001;
        load_ratings();
        queue_sample(0, 0, 32767, 1'b1);
        queue_sample(0, 32767, -32768, 1'b0);
        queue_sample(0, -32768, 21845, 1'b1);
        queue_sample(0, 0, -21846, 1'b1);
        queue_sample(1, -32768, 0, 1'b0);
        queue_sample(1, 0, -1, 1'b1);
        queue_sample(1, 0, 32767, 1'b0);
        queue_sample(2, 0, -32768, 1'b1);
        queue_sample(2, -1, 4660, 1'b1);
        queue_sample(3, 2000, 1, 1'b0);
        queue_sample(3, -2000, -2, 1'b1);
        queue_sample(3, 2000, 16384, 1'b0);
        for (int k = 0; k < 6; k++)
            queue_sample(3, 0, $urandom, 1'b1);
        settle();

        for (int ph = 0; ph < RANDOM_SETS; ph++) begin
            pick_ratings();
            load_ratings();
            for (int n = 0; n < SET_SAMPLES; n++) begin
                m    = $urandom_range(0, MOTORS - 1);
                roll = $urandom_range(0, 99);
                base = int'(next_nominal[m]);
                top  = 2 * base + 100;
                if (top > 32767) top = 32767;
                if (roll < 3) begin
                    cur = $urandom;
                end else if (roll < 12) begin
                    mag = $urandom_range(0, top);
                    cur = $urandom_range(0, 1) ? -mag : mag;
                end else begin
                    // overload and rest runs per motor
                    if ($urandom_range(0, 5) == 0) surging[m] = !surging[m];
                    if (surging[m]) begin
                        low = base + base / 2;
                        if (low > top) low = top;
                    end else begin
                        low = 0;
                        top = base / 2;
                    end
                    mag = $urandom_range(low, top);
                    cur = $urandom_range(0, 1) ? -mag : mag;
                end
                queue_sample(m, cur, $urandom, $urandom_range(0, 3) != 0);
            end
            settle();
        end

        // long burst without idling at full-scale current on motor 3
        pick_ratings();
        next_nominal[3] = 0;
        next_peak[3]    = 32767;
        load_ratings();
        no_idle = 1'b1;
        for (int n = 0; n < SURGE_SAMPLES; n++)
            queue_sample(3, $urandom_range(0, 1) ? -32768 : 32767, $urandom,
                         $urandom_range(0, 1) != 0);
        queue_sample(3, 0, $urandom, 1'b1);
        queue_sample(3, -32768, $urandom, 1'b1);
        queue_sample(0, $urandom, $urandom, 1'b0);
        queue_sample(3, 32767, $urandom, 1'b0);
        settle();
        no_idle = 1'b0;

        repeat (10) @(posedge i_clk);
        $display("checked %0d results from %0d items over %0d rating sets",
                 verdicts_checked, samples_sent, rating_sets);
        $display("%0d fault raises, %0d releases, %0d voltage publications, %0d mismatches",
                 trips_seen, releases_seen, publishes_seen, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
